/* src/clppr_pkg.sv */
// ----------------------------------------------------------------------------
// clppr_pkg: shared types and constants for the card list
// Card, payload and cell control types, operation and status codes.
// ----------------------------------------------------------------------------
package clppr_pkg;

  // number of cells in the row
  localparam int unsigned DEPTH = 64;
  // width of the internal counters, able to hold DEPTH itself
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  // width of the reported counts
  localparam int unsigned LEN_W = 7;

  // operation codes
  localparam logic [2:0] FN_APPEND = 3'd0;
  localparam logic [2:0] FN_PUSH   = 3'd1;
  localparam logic [2:0] FN_POP    = 3'd2;
  localparam logic [2:0] FN_REMOVE = 3'd3;
  localparam logic [2:0] FN_QUERY  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [3:0] rank;
    logic [1:0] suit;
  } card_t;

  typedef struct packed {
    logic [2:0] func;
    logic [3:0] card_rank;
    logic [1:0] card_suit;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [3:0]       out_rank;
    logic [1:0]       out_suit;
    logic [LEN_W-1:0] list_length;
    logic [LEN_W-1:0] suit_total;
  } out_item_t;

  // per-cell control: load new card, take left neighbor, take right neighbor
  typedef struct packed {
    logic load;
    logic shr;
    logic shl;
  } cell_ctrl_t;

endpackage

/* src/clppr_cell.sv */
// ----------------------------------------------------------------------------
// clppr_cell: one slot of the card row
// Holds one card, moves it to a neighbor or loads a new one, and flags a key
// match for the remove search.
// ----------------------------------------------------------------------------
module clppr_cell (
  input  logic                clk_i,
  input  clppr_pkg::cell_ctrl_t ctrl_i,
  input  clppr_pkg::card_t    new_card_i,
  input  clppr_pkg::card_t    left_card_i,
  input  clppr_pkg::card_t    right_card_i,
  output clppr_pkg::card_t    card_o,
  output logic                key_eq_o
);
  import clppr_pkg::*;

  card_t card_q;
  card_t card_d;

  // next card: new card, left neighbor, right neighbor or hold
  always_comb begin
    priority if (ctrl_i.load) begin
      card_d = new_card_i;
    end else if (ctrl_i.shr) begin
      card_d = left_card_i;
    end else if (ctrl_i.shl) begin
      card_d = right_card_i;
    end else begin
      card_d = card_q;
    end
  end

  // card storage, no reset needed
  always_ff @(posedge clk_i) begin
    card_q <= card_d;
  end

  assign card_o   = card_q;
  assign key_eq_o = (card_q == new_card_i);

endmodule

/* src/card_list_push_pop_remove.sv */
// ----------------------------------------------------------------------------
// card_list_push_pop_remove: ordered card list with deque ops and removal
// A row of cells holds the list, front in cell 0; counts kept alongside.
// ----------------------------------------------------------------------------
// One operation per transfer, one transfer per cycle unless the output
// stalls: every operation, remove included, completes in the cycle it is
// accepted, because the whole row of DEPTH cells shifts at once and the remove
// search is a single lowest-match mask over the row. The result is registered
// and appears in the cycle after the input transfer; a new item is taken while
// the previous result is being transferred out. After reset the list is empty.
module card_list_push_pop_remove (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  clppr_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output clppr_pkg::out_item_t out_data_o
);
  import clppr_pkg::*;

  logic                 in_fire;
  card_t                new_card;
  card_t                cards   [DEPTH];
  logic [DEPTH-1:0]     key_eq;
  logic [DEPTH-1:0]     occ;
  logic [DEPTH-1:0]     tail_hit;
  logic [DEPTH-1:0]     match;
  logic [DEPTH-1:0]     low_match;
  logic [DEPTH-1:0]     rm_mask;
  logic [DEPTH-1:0]     load_vec;
  logic [DEPTH-1:0]     shl_vec;
  logic                 shr_all;
  logic [CNT_W-1:0]     count_q;
  logic [CNT_W-1:0]     count_d;
  logic [CNT_W-1:0]     suit_q  [4];
  logic [CNT_W-1:0]     suit_d  [4];
  logic                 full;
  logic                 empty;
  logic [1:0]           status;
  card_t                popped;
  logic                 out_valid_q;
  out_item_t            out_data_q;

  // input transfer
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign new_card   = '{rank: in_data_i.card_rank, suit: in_data_i.card_suit};

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_row
    localparam logic [CNT_W-1:0] Idx = CNT_W'(i);
    cell_ctrl_t ctrl;
    card_t      left_card;
    card_t      right_card;

    assign occ[i]      = (Idx < count_q);
    assign tail_hit[i] = (Idx == count_q);
    assign ctrl.load   = in_fire & (load_vec[i] | (shr_all & (i == 0)));
    assign ctrl.shr    = in_fire & shr_all;
    assign ctrl.shl    = in_fire & shl_vec[i];

    if (i == 0) begin : g_first
      assign left_card = new_card;
    end else begin : g_mid_l
      assign left_card = cards[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_card = '0;
    end else begin : g_mid_r
      assign right_card = cards[i+1];
    end

    clppr_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .new_card_i  (new_card),
      .left_card_i (left_card),
      .right_card_i(right_card),
      .card_o      (cards[i]),
      .key_eq_o    (key_eq[i])
    );
  end

  // first match and the cells at or above it, which close the gap
  assign match     = key_eq & occ;
  assign low_match = match & (~match + DEPTH'(1));
  assign rm_mask   = (match == '0) ? '0 : ~(low_match - DEPTH'(1));

  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  // operation decode and count update
  always_comb begin
    count_d  = count_q;
    suit_d   = suit_q;
    status   = ST_OK;
    load_vec = '0;
    shl_vec  = '0;
    shr_all  = 1'b0;
    popped   = '0;
    unique case (in_data_i.func)
      FN_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          load_vec                   = tail_hit;
          count_d                    = count_q + CNT_W'(1);
          suit_d[in_data_i.card_suit] = suit_q[in_data_i.card_suit] + CNT_W'(1);
        end
      end
      FN_PUSH: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          shr_all                    = 1'b1;
          count_d                    = count_q + CNT_W'(1);
          suit_d[in_data_i.card_suit] = suit_q[in_data_i.card_suit] + CNT_W'(1);
        end
      end
      FN_POP: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          shl_vec                = '1;
          popped                 = cards[0];
          count_d                = count_q - CNT_W'(1);
          suit_d[cards[0].suit]  = suit_q[cards[0].suit] - CNT_W'(1);
        end
      end
      FN_REMOVE: begin
        if (match == '0) begin
          status = ST_NOT_FOUND;
        end else begin
          shl_vec                    = rm_mask;
          count_d                    = count_q - CNT_W'(1);
          suit_d[in_data_i.card_suit] = suit_q[in_data_i.card_suit] - CNT_W'(1);
        end
      end
      default: begin
        // query only, unused codes too
      end
    endcase
  end

  // counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int k = 0; k < 4; k++) begin
        suit_q[k] <= '0;
      end
    end else if (in_fire) begin
      count_q <= count_d;
      suit_q  <= suit_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q.status      <= status;
      out_data_q.out_rank    <= popped.rank;
      out_data_q.out_suit    <= popped.suit;
      out_data_q.list_length <= LEN_W'(count_d);
      out_data_q.suit_total  <= LEN_W'(suit_d[in_data_i.card_suit]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("list length above depth");

  a_suit_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CNT_W+2)'(suit_q[0]) + (CNT_W+2)'(suit_q[1]) + (CNT_W+2)'(suit_q[2])
     + (CNT_W+2)'(suit_q[3])) == (CNT_W+2)'(count_q))
    else $error("suit counts do not sum to list length");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.func == FN_POP && !empty)
    |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("pop did not shrink the list");

  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

endmodule
